>>> rtl/sal_pkg.sv
// sal_pkg: shared types and constants for the speech activity listener
// holds the state encoding, op codes, register indexes and stream field positions
// no dependencies
package sal_pkg;

    // listener states
    typedef enum logic [2:0] {
        ST_STARTUP     = 3'd0,
        ST_IDLE        = 3'd1,
        ST_SPEECH_CAND = 3'd2,
        ST_LISTENING   = 3'd3,
        ST_END_CAND    = 3'd4,
        ST_REACTING    = 3'd5,
        ST_COOLDOWN    = 3'd6,
        ST_SLEEPING    = 3'd7
    } state_t;

    // op codes carried in s_tuser
    localparam logic [1:0] OP_UPDATE     = 2'd0;
    localparam logic [1:0] OP_RESTART    = 2'd1;
    localparam logic [1:0] OP_FORCE_IDLE = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_WAIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_SILENCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_HOLD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_REACT_INTV = 3'd6;

    localparam int MS_W    = 32;
    localparam int LEVEL_W = 16;
    localparam int OP_W    = 2;

    // stream widths
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 48;

    // input tdata field positions
    localparam int S_NOW_LO      = 0;
    localparam int S_HEALTHY     = 32;
    localparam int S_READY       = 33;
    localparam int S_COMPLETE    = 34;
    localparam int S_SUPPRESSED  = 35;
    localparam int S_AVAIL       = 36;
    localparam int S_LEVEL_LO    = 37;
    localparam int S_START_TH_LO = 53;
    localparam int S_END_TH_LO   = 69;

    // reset values of the configuration registers
    localparam logic [MS_W-1:0] RST_STARTUP_WAIT   = 32'd1000;
    localparam logic [MS_W-1:0] RST_COOLDOWN       = 32'd1500;
    localparam logic [MS_W-1:0] RST_SLEEP_SILENCE  = 32'd30000;
    localparam logic [MS_W-1:0] RST_START_HOLD     = 32'd200;
    localparam logic [MS_W-1:0] RST_END_HOLD       = 32'd600;
    localparam logic [MS_W-1:0] RST_MIN_SPEECH     = 32'd400;
    localparam logic [MS_W-1:0] RST_MIN_REACT_INTV = 32'd3000;

endpackage

>>> rtl/speech_activity_listener_fsm_core.sv
// speech_activity_listener_fsm_core: eight-state speech activity listener
// input register, one pass of timer compares and state decode, result register
// depends on sal_pkg
//
//  channel | direction | tdata                                  | tuser
//  s_      | in        | now, flags, level, start/end threshold | op
//  m_      | out       | new/prior state, flags, speech length  | reaction kind
//  cfg_    | in        | 7 x 32-bit duration registers, write only
//
// one item per cycle while the m_ side takes results; an item passes through the input
// register and then leaves through the result register.
// the state and time marks update when an item moves from the input register to the
// result register, so the following item sees them at once.
// aresetn (synchronous, active low) restores startup, zero marks and default durations.
// a stalled m_ side holds the result; the input register still takes one more item.
module speech_activity_listener_fsm_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] now_ms, [32] audio_healthy, [33] audio_ready, [34] reaction_complete,
    // [35] detection_suppressed, [36] sample_available, [52:37] level,
    // [68:53] start_threshold, [84:69] end_threshold, [87:85] zero
    input  logic [sal_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] op
    input  logic [sal_pkg::OP_W-1:0]       s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] new_state, [5:3] prior_state, [6] state_changed, [7] woke_from_sleep,
    // [8] reaction_requested, [40:9] completed_speech_ms, [47:41] zero
    output logic [sal_pkg::M_DATA_W-1:0]   m_tdata,
    // [0] reaction_kind
    output logic                           m_tuser,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [sal_pkg::MS_W-1:0]       cfg_wdata
);
    import sal_pkg::*;

    // configuration registers
    logic [MS_W-1:0] startup_wait_reg, cooldown_reg, sleep_silence_reg;
    logic [MS_W-1:0] start_hold_reg, end_hold_reg, min_speech_reg, min_react_intv_reg;

    // input and result stage
    logic                in_valid_reg;
    logic [S_DATA_W-1:0] in_data_reg;
    logic [OP_W-1:0]     in_op_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_kind_reg;
    logic                out_free;
    logic                advance;

    // listener state; an active reaction is the same as being in reacting
    state_t          state_reg, state_next;
    logic [MS_W-1:0] entered_reg, entered_next;
    logic [MS_W-1:0] cand_reg, cand_next;
    logic [MS_W-1:0] speech_start_reg, speech_start_next;
    logic [MS_W-1:0] end_cand_reg, end_cand_next;
    logic [MS_W-1:0] last_act_reg, last_act_next;
    logic [MS_W-1:0] last_react_reg, last_react_next;
    logic [MS_W-1:0] speech_len_reg, speech_len_next;
    logic            has_reacted_reg, has_reacted_next;
    logic            woke;
    logic            react;

    // unpacked item fields
    logic [MS_W-1:0]    now_ms;
    logic               healthy, ready, complete, suppressed, avail;
    logic [LEVEL_W-1:0] level, start_th, end_th;
    logic               op_restart, op_force_idle, op_mark;

    // decoded conditions
    logic            t_startup, t_cool, t_sleep, t_hold, t_end, interval_ok;
    logic [MS_W-1:0] speech_len;
    logic            long_enough, loud, quiet, smp;

    assign now_ms     = in_data_reg[S_NOW_LO +: MS_W];
    assign healthy    = in_data_reg[S_HEALTHY];
    assign ready      = in_data_reg[S_READY];
    assign complete   = in_data_reg[S_COMPLETE];
    assign suppressed = in_data_reg[S_SUPPRESSED];
    assign avail      = in_data_reg[S_AVAIL];
    assign level      = in_data_reg[S_LEVEL_LO +: LEVEL_W];
    assign start_th   = in_data_reg[S_START_TH_LO +: LEVEL_W];
    assign end_th     = in_data_reg[S_END_TH_LO +: LEVEL_W];

    always_comb begin
        op_restart    = 1'b0;
        op_force_idle = 1'b0;
        case (in_op_reg)
            OP_RESTART:    op_restart    = 1'b1;
            OP_FORCE_IDLE: op_force_idle = 1'b1;
            default:       ;
        endcase
    end
    assign op_mark = op_restart | op_force_idle;

    // wrap-around timers
    assign t_startup   = (now_ms - entered_reg) >= startup_wait_reg;
    assign t_cool      = (now_ms - entered_reg) >= cooldown_reg;
    assign t_sleep     = (now_ms - last_act_reg) >= sleep_silence_reg;
    assign t_hold      = (now_ms - cand_reg) >= start_hold_reg;
    assign t_end       = (now_ms - end_cand_reg) >= end_hold_reg;
    assign interval_ok = !has_reacted_reg || ((now_ms - last_react_reg) >= min_react_intv_reg);
    assign speech_len  = end_cand_reg - speech_start_reg;
    assign long_enough = speech_len >= min_speech_reg;
    assign loud        = level >= start_th;
    assign quiet       = level < end_th;
    assign smp         = avail && !suppressed;

    // handshake: the input register moves whenever the result register can take it
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        if (op_restart) begin
            state_next = ST_STARTUP;
        end else if (op_force_idle) begin
            state_next = ST_IDLE;
        end else if (healthy) begin
            case (state_reg)
                ST_STARTUP: if (ready && t_startup) state_next = ST_IDLE;
                ST_REACTING: if (complete) state_next = ST_COOLDOWN;
                ST_COOLDOWN: if (t_cool) state_next = ST_IDLE;
                ST_IDLE: begin
                    if (t_sleep) state_next = ST_SLEEPING;
                    else if (smp && loud) state_next = ST_SPEECH_CAND;
                end
                ST_SLEEPING: if (smp && loud) state_next = ST_SPEECH_CAND;
                ST_SPEECH_CAND: begin
                    if (smp) begin
                        if (!loud) state_next = ST_IDLE;
                        else if (t_hold) state_next = ST_LISTENING;
                    end
                end
                ST_LISTENING: if (smp && quiet) state_next = ST_END_CAND;
                ST_END_CAND: begin
                    if (smp) begin
                        if (!quiet) state_next = ST_LISTENING;
                        else if (t_end) begin
                            state_next = (long_enough && interval_ok) ? ST_REACTING
                                                                      : ST_COOLDOWN;
                        end
                    end
                end
                default: state_next = state_reg;
            endcase
        end
    end

    // time marks, speech length and result flags
    always_comb begin
        entered_next      = entered_reg;
        cand_next         = cand_reg;
        speech_start_next = speech_start_reg;
        end_cand_next     = end_cand_reg;
        last_act_next     = last_act_reg;
        last_react_next   = last_react_reg;
        speech_len_next   = speech_len_reg;
        has_reacted_next  = has_reacted_reg;
        woke              = 1'b0;
        react             = 1'b0;
        if (op_mark) begin
            entered_next      = now_ms;
            cand_next         = now_ms;
            speech_start_next = now_ms;
            end_cand_next     = now_ms;
            last_act_next     = now_ms;
            if (op_restart) begin
                last_react_next  = now_ms;
                speech_len_next  = '0;
                has_reacted_next = 1'b0;
            end
        end else if (healthy) begin
            if (state_next != state_reg) entered_next = now_ms;
            case (state_reg)
                ST_STARTUP, ST_COOLDOWN: begin
                    if (state_next == ST_IDLE) last_act_next = now_ms;
                end
                ST_IDLE, ST_SLEEPING: begin
                    if (state_next == ST_SPEECH_CAND) begin
                        woke          = (state_reg == ST_SLEEPING);
                        cand_next     = now_ms;
                        last_act_next = now_ms;
                    end
                end
                ST_SPEECH_CAND: begin
                    if (smp && loud) begin
                        last_act_next = now_ms;
                        if (t_hold) speech_start_next = cand_reg;
                    end
                end
                ST_LISTENING: begin
                    if (smp) begin
                        last_act_next = now_ms;
                        if (quiet) end_cand_next = now_ms;
                    end
                end
                ST_END_CAND: begin
                    if (smp && (!quiet || t_end)) last_act_next = now_ms;
                    if (smp && quiet && t_end) begin
                        speech_len_next = speech_len;
                        if (long_enough && interval_ok) begin
                            react            = 1'b1;
                            has_reacted_next = 1'b1;
                            last_react_next  = now_ms;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_wait_reg   <= RST_STARTUP_WAIT;
            cooldown_reg       <= RST_COOLDOWN;
            sleep_silence_reg  <= RST_SLEEP_SILENCE;
            start_hold_reg     <= RST_START_HOLD;
            end_hold_reg       <= RST_END_HOLD;
            min_speech_reg     <= RST_MIN_SPEECH;
            min_react_intv_reg <= RST_MIN_REACT_INTV;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_STARTUP_WAIT:   startup_wait_reg   <= cfg_wdata;
                REG_COOLDOWN:       cooldown_reg       <= cfg_wdata;
                REG_SLEEP_SILENCE:  sleep_silence_reg  <= cfg_wdata;
                REG_START_HOLD:     start_hold_reg     <= cfg_wdata;
                REG_END_HOLD:       end_hold_reg       <= cfg_wdata;
                REG_MIN_SPEECH:     min_speech_reg     <= cfg_wdata;
                REG_MIN_REACT_INTV: min_react_intv_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // listener state, updated as each item passes to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_STARTUP;
            entered_reg      <= '0;
            cand_reg         <= '0;
            speech_start_reg <= '0;
            end_cand_reg     <= '0;
            last_act_reg     <= '0;
            last_react_reg   <= '0;
            speech_len_reg   <= '0;
            has_reacted_reg  <= 1'b0;
        end else if (advance) begin
            state_reg        <= state_next;
            entered_reg      <= entered_next;
            cand_reg         <= cand_next;
            speech_start_reg <= speech_start_next;
            end_cand_reg     <= end_cand_next;
            last_act_reg     <= last_act_next;
            last_react_reg   <= last_react_next;
            speech_len_reg   <= speech_len_next;
            has_reacted_reg  <= has_reacted_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {7'd0, speech_len_next, react, woke,
                             (state_next != state_reg), state_reg, state_next};
            out_kind_reg <= react;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

>>> verif/speech_activity_listener_check.sv
`timescale 1ns / 100ps
// speech_activity_listener_check: watches the item, result and config channels,
// predicts each result from its own copy of the listener state and compares it
// depends on sal_pkg
module speech_activity_listener_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sal_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [sal_pkg::OP_W-1:0]       s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sal_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           m_tuser,
    input  logic                           cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [sal_pkg::MS_W-1:0]       cfg_wdata,
    output int unsigned                    mismatches,
    output int unsigned                    outstanding
);
    import sal_pkg::*;

    typedef struct {
        state_t           new_state;
        state_t           prior_state;
        logic             changed;
        logic             woke;
        logic             nod_req;
        logic             nod_kind;
        logic [MS_W-1:0]  speech_len;
    } listen_result_t;

    // duration registers
    logic [MS_W-1:0] startup_wait, cooldown_len, sleep_silence;
    logic [MS_W-1:0] start_hold, end_hold, min_speech, min_react_gap;

    // listener state and time marks
    state_t          cur_state;
    logic [MS_W-1:0] entered_ms, cand_ms, speech_ms, end_cand_ms;
    logic [MS_W-1:0] activity_ms, reaction_ms, speech_len_ms;
    logic            reacted, nod_active;

    listen_result_t pending_outcomes[$];
    listen_result_t want;
    int unsigned    fail_count = 0;

    // wrapping elapsed-time compare
    function automatic bit timer_expired(input logic [MS_W-1:0] now_v,
                                         input logic [MS_W-1:0] mark_v,
                                         input logic [MS_W-1:0] dur_v);
        logic [MS_W-1:0] span;
        span = now_v - mark_v;
        return span >= dur_v;
    endfunction

    function automatic void enter_state(input state_t next_st, input logic [MS_W-1:0] now_v);
        if (next_st != cur_state) begin
            cur_state  = next_st;
            entered_ms = now_v;
        end
    endfunction

    function automatic void mark_all(input logic [MS_W-1:0] now_v);
        entered_ms  = now_v;
        cand_ms     = now_v;
        speech_ms   = now_v;
        end_cand_ms = now_v;
        activity_ms = now_v;
    endfunction

    // one listener step: updates the state copy and returns the result it causes
    function automatic listen_result_t predict_listener_step(input logic [S_DATA_W-1:0] data,
                                                             input logic [OP_W-1:0] op);
        listen_result_t    res;
        logic [MS_W-1:0]   now_v;
        logic              healthy, ready, complete, sample_ok;
        logic [LEVEL_W-1:0] lvl, start_th, end_th;
        logic              long_enough, interval_ok;

        now_v     = data[S_NOW_LO +: MS_W];
        healthy   = data[S_HEALTHY];
        ready     = data[S_READY];
        complete  = data[S_COMPLETE];
        sample_ok = data[S_AVAIL] && !data[S_SUPPRESSED];
        lvl       = data[S_LEVEL_LO +: LEVEL_W];
        start_th  = data[S_START_TH_LO +: LEVEL_W];
        end_th    = data[S_END_TH_LO +: LEVEL_W];

        res.prior_state = cur_state;
        res.woke        = 1'b0;
        res.nod_req     = 1'b0;

        if (op == OP_RESTART) begin
            cur_state     = ST_STARTUP;
            nod_active    = 1'b0;
            mark_all(now_v);
            reaction_ms   = now_v;
            speech_len_ms = '0;
            reacted       = 1'b0;
        end else if (op == OP_FORCE_IDLE) begin
            cur_state  = ST_IDLE;
            nod_active = 1'b0;
            mark_all(now_v);
        end else if (healthy) begin
            case (cur_state)
                ST_STARTUP: begin
                    if (ready && timer_expired(now_v, entered_ms, startup_wait)) begin
                        activity_ms = now_v;
                        enter_state(ST_IDLE, now_v);
                    end
                end
                ST_REACTING: begin
                    if (complete) begin
                        nod_active = 1'b0;
                        enter_state(ST_COOLDOWN, now_v);
                    end
                end
                ST_COOLDOWN: begin
                    if (timer_expired(now_v, entered_ms, cooldown_len)) begin
                        activity_ms = now_v;
                        enter_state(ST_IDLE, now_v);
                    end
                end
                ST_IDLE, ST_SLEEPING: begin
                    // idle silence timer runs even without a sample
                    if (cur_state == ST_IDLE &&
                        timer_expired(now_v, activity_ms, sleep_silence)) begin
                        enter_state(ST_SLEEPING, now_v);
                    end else if (sample_ok && lvl >= start_th) begin
                        res.woke    = (cur_state == ST_SLEEPING);
                        cand_ms     = now_v;
                        activity_ms = now_v;
                        enter_state(ST_SPEECH_CAND, now_v);
                    end
                end
                ST_SPEECH_CAND: begin
                    if (sample_ok) begin
                        if (lvl < start_th) begin
                            enter_state(ST_IDLE, now_v);
                        end else begin
                            activity_ms = now_v;
                            if (timer_expired(now_v, cand_ms, start_hold)) begin
                                speech_ms = cand_ms;
                                enter_state(ST_LISTENING, now_v);
                            end
                        end
                    end
                end
                ST_LISTENING: begin
                    if (sample_ok) begin
                        activity_ms = now_v;
                        if (lvl < end_th) begin
                            end_cand_ms = now_v;
                            enter_state(ST_END_CAND, now_v);
                        end
                    end
                end
                ST_END_CAND: begin
                    if (sample_ok) begin
                        if (lvl >= end_th) begin
                            activity_ms = now_v;
                            enter_state(ST_LISTENING, now_v);
                        end else if (timer_expired(now_v, end_cand_ms, end_hold)) begin
                            // speech closed: nod if long enough and not too soon
                            speech_len_ms = end_cand_ms - speech_ms;
                            activity_ms   = now_v;
                            long_enough   = speech_len_ms >= min_speech;
                            interval_ok   = !reacted ||
                                            timer_expired(now_v, reaction_ms, min_react_gap);
                            if (!long_enough || !interval_ok) begin
                                enter_state(ST_COOLDOWN, now_v);
                            end else begin
                                nod_active  = 1'b1;
                                reacted     = 1'b1;
                                reaction_ms = now_v;
                                enter_state(ST_REACTING, now_v);
                                res.nod_req = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        res.new_state  = cur_state;
        res.changed    = (cur_state != res.prior_state);
        res.nod_kind   = res.nod_req;
        res.speech_len = speech_len_ms;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [MS_W-1:0] exp_v,
                               input logic [MS_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            startup_wait  = RST_STARTUP_WAIT;
            cooldown_len  = RST_COOLDOWN;
            sleep_silence = RST_SLEEP_SILENCE;
            start_hold    = RST_START_HOLD;
            end_hold      = RST_END_HOLD;
            min_speech    = RST_MIN_SPEECH;
            min_react_gap = RST_MIN_REACT_INTV;
            cur_state     = ST_STARTUP;
            mark_all('0);
            reaction_ms   = '0;
            speech_len_ms = '0;
            reacted       = 1'b0;
            nod_active    = 1'b0;
            pending_outcomes.delete();
        end else begin
            // compare a delivered result with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result with none expected, actual tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("new_state", MS_W'(want.new_state), MS_W'(m_tdata[2:0]));
                    check_field("prior_state", MS_W'(want.prior_state), MS_W'(m_tdata[5:3]));
                    check_field("state_changed", MS_W'(want.changed), MS_W'(m_tdata[6]));
                    check_field("woke_from_sleep", MS_W'(want.woke), MS_W'(m_tdata[7]));
                    check_field("reaction_requested", MS_W'(want.nod_req), MS_W'(m_tdata[8]));
                    check_field("completed_speech_ms", want.speech_len, m_tdata[40:9]);
                    check_field("reaction_kind", MS_W'(want.nod_kind), MS_W'(m_tuser));
                end
            end
            // predict each accepted item
            if (s_tvalid && s_tready)
                pending_outcomes.push_back(predict_listener_step(s_tdata, s_tuser));
            // duration register writes, unknown indexes ignored
            if (cfg_we) begin
                case (cfg_idx)
                    REG_STARTUP_WAIT:   startup_wait  = cfg_wdata;
                    REG_COOLDOWN:       cooldown_len  = cfg_wdata;
                    REG_SLEEP_SILENCE:  sleep_silence = cfg_wdata;
                    REG_START_HOLD:     start_hold    = cfg_wdata;
                    REG_END_HOLD:       end_hold      = cfg_wdata;
                    REG_MIN_SPEECH:     min_speech    = cfg_wdata;
                    REG_MIN_REACT_INTV: min_react_gap = cfg_wdata;
                    default: ;
                endcase
            end
        end
        mismatches  <= fail_count;
        outstanding <= pending_outcomes.size();
    end

endmodule

>>> verif/speech_activity_listener_fsm_core_test.sv
`timescale 1ns / 100ps
// speech_activity_listener_fsm_core_test: clock, reset, item and config stimulus
// and verdict for the listener core; checking lives in speech_activity_listener_check
// depends on sal_pkg, speech_activity_listener_fsm_core, speech_activity_listener_check
module speech_activity_listener_fsm_core_test;
    import sal_pkg::*;

    // status flag bits, in tdata order from audio_healthy up
    localparam logic [4:0] F_HEALTHY  = 5'b00001;
    localparam logic [4:0] F_READY    = 5'b00010;
    localparam logic [4:0] F_COMPLETE = 5'b00100;
    localparam logic [4:0] F_SUPPRESS = 5'b01000;
    localparam logic [4:0] F_AVAIL    = 5'b10000;
    localparam logic [4:0] F_OK       = F_HEALTHY | F_READY | F_AVAIL;
    localparam logic [4:0] F_ALL      = 5'b11111;

    localparam logic [OP_W-1:0]      OP_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [LEVEL_W-1:0]   LVL_MAX    = 16'hFFFF;
    localparam logic [MS_W-1:0]      MS_MAX     = 32'hFFFF_FFFF;
    localparam int                   HOLD_CYCLES = 80;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [MS_W-1:0]       cfg_wdata = '0;
    int unsigned           mismatches, outstanding;

    // stimulus state
    logic [MS_W-1:0]    t_ms;
    logic [LEVEL_W-1:0] start_lvl = 16'd2000;
    logic [LEVEL_W-1:0] end_lvl = 16'd1000;
    bit                 loud = 1'b0;
    bit                 tx_calm = 1'b0;
    logic               hold_req = 1'b0;

    // receiver state
    int   rx_cycles = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always #1 aclk = ~aclk;

    speech_activity_listener_fsm_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    speech_activity_listener_check checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side: random backpressure, a calm window and one long hold-off
    always @(posedge aclk) begin
        rx_cycles <= rx_cycles + 1;
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (rx_cycles >= 300 && rx_cycles < 700) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 6);
        end
    end

    // offer one item and wait until it is taken
    task automatic offer_item(input logic [OP_W-1:0] op, input logic [MS_W-1:0] now_v,
                              input logic [4:0] flags, input logic [LEVEL_W-1:0] lvl,
                              input logic [LEVEL_W-1:0] start_th,
                              input logic [LEVEL_W-1:0] end_th);
        logic [S_DATA_W-1:0] word;
        word = '0;
        word[S_NOW_LO +: MS_W]          = now_v;
        word[S_HEALTHY +: 5]            = flags;
        word[S_LEVEL_LO +: LEVEL_W]     = lvl;
        word[S_START_TH_LO +: LEVEL_W]  = start_th;
        word[S_END_TH_LO +: LEVEL_W]    = end_th;
        while (!tx_calm && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and let every expected result come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic program_durations(input logic [MS_W-1:0] wait_v, cool_v, sleep_v,
                                     start_v, end_v, min_v, gap_v);
        write_register(REG_STARTUP_WAIT, wait_v);
        write_register(REG_COOLDOWN, cool_v);
        write_register(REG_SLEEP_SILENCE, sleep_v);
        write_register(REG_START_HOLD, start_v);
        write_register(REG_END_HOLD, end_v);
        write_register(REG_MIN_SPEECH, min_v);
        write_register(REG_MIN_REACT_INTV, gap_v);
        cfg_we <= 1'b0;
    endtask

    // loud and quiet runs with random timing, flags and some noise
    task automatic random_burst(input int count);
        logic [OP_W-1:0]    op;
        logic [4:0]         flags;
        logic [LEVEL_W-1:0] lvl;
        int                 r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            op = (r < 2) ? OP_RESTART : (r < 4) ? OP_FORCE_IDLE :
                 (r < 6) ? OP_SPARE : OP_UPDATE;
            r = $urandom_range(0, 99);
            if (r < 1)
                t_ms = $urandom;
            else if (r < 6)
                t_ms = t_ms + $urandom_range(500, 40000);
            else
                t_ms = t_ms + $urandom_range(0, 80);
            flags = '0;
            if ($urandom_range(0, 99) >= 3)  flags |= F_HEALTHY;
            if ($urandom_range(0, 99) >= 10) flags |= F_READY;
            if ($urandom_range(0, 99) < 35)  flags |= F_COMPLETE;
            if ($urandom_range(0, 99) < 7)   flags |= F_SUPPRESS;
            if ($urandom_range(0, 99) >= 8)  flags |= F_AVAIL;
            // switch between loud and quiet, sometimes with new thresholds
            if ($urandom_range(0, 9) == 0) begin
                loud = !loud;
                if ($urandom_range(0, 1) == 0) begin
                    start_lvl = LEVEL_W'($urandom_range(0, 65535));
                    end_lvl = ($urandom_range(0, 9) == 0)
                              ? LEVEL_W'($urandom_range(0, 65535))
                              : LEVEL_W'($urandom_range(0, start_lvl));
                end
            end
            if ($urandom_range(0, 9) == 0)
                lvl = LEVEL_W'($urandom_range(0, 65535));
            else if (loud)
                lvl = LEVEL_W'($urandom_range(start_lvl, 65535));
            else if (end_lvl == 0)
                lvl = '0;
            else
                lvl = LEVEL_W'($urandom_range(0, end_lvl - 1));
            offer_item(op, t_ms, flags, lvl, start_lvl, end_lvl);
        end
    endtask

    // run limit
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk through every state with default durations
        offer_item(OP_UPDATE, 32'd500, F_READY | F_AVAIL, LVL_MAX, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'd999, F_OK, 16'd0, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'd2000, F_HEALTHY | F_AVAIL, 16'd0, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'd1000, F_OK, 16'd0, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'd1010, F_HEALTHY | F_READY, LVL_MAX, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'd1020, F_OK | F_SUPPRESS, LVL_MAX, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'd1030, F_OK, 16'd0, 16'd0, 16'd0);
        offer_item(OP_SPARE, 32'd1230, F_OK, LVL_MAX, LVL_MAX, 16'd0);
        offer_item(OP_UPDATE, 32'd1600, F_OK, 16'd99, LVL_MAX, 16'd100);
        // level back above end threshold: hysteresis returns to listening
        offer_item(OP_UPDATE, 32'd1700, F_OK, 16'd200, LVL_MAX, 16'd100);
        offer_item(OP_UPDATE, 32'd1800, F_OK, 16'd0, 16'd0, LVL_MAX);
        offer_item(OP_UPDATE, 32'd2400, F_OK, 16'd0, 16'd0, LVL_MAX);
        offer_item(OP_UPDATE, 32'd2500, F_OK, 16'd0, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'd2600, F_OK | F_COMPLETE, 16'd0, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'd4100, F_HEALTHY, 16'd0, 16'd0, 16'd0);
        // second speech closes too soon after the first nod
        offer_item(OP_UPDATE, 32'd4200, F_OK, 16'd5000, 16'd4000, 16'd3000);
        offer_item(OP_UPDATE, 32'd4400, F_OK, 16'd5000, 16'd4000, 16'd3000);
        offer_item(OP_UPDATE, 32'd4700, F_OK, 16'd10, 16'd4000, 16'd3000);
        offer_item(OP_UPDATE, 32'd5300, F_OK, 16'd10, 16'd4000, 16'd3000);
        offer_item(OP_UPDATE, 32'd6800, F_HEALTHY, 16'd0, 16'd0, 16'd0);
        // idle silence into sleep, then wake on a loud sample
        offer_item(OP_UPDATE, 32'd36800, F_HEALTHY, 16'd0, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'd36900, F_OK, 16'd5000, 16'd4000, 16'd3000);
        // forced idle and restart, with timestamps wrapping through zero
        offer_item(OP_FORCE_IDLE, 32'hFFFF_FFF0, F_OK | F_COMPLETE | F_SUPPRESS,
                   16'd1234, 16'd0, 16'd0);
        offer_item(OP_UPDATE, 32'h0000_0010, F_OK, 16'd5000, 16'd4000, 16'd3000);
        offer_item(OP_RESTART, MS_MAX, F_ALL, LVL_MAX, LVL_MAX, LVL_MAX);
        offer_item(OP_UPDATE, 32'd999, F_OK, 16'd0, 16'd0, 16'd0);
        t_ms = 32'd1000;

        // random phases, each under its own duration setting
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase)
                1: program_durations('0, '0, '0, '0, '0, '0, '0);
                3: begin
                    write_register(REG_UNUSED, $urandom);
                    program_durations(MS_MAX, MS_MAX, MS_MAX, MS_MAX, MS_MAX, MS_MAX, MS_MAX);
                end
                4: program_durations(RST_STARTUP_WAIT, RST_COOLDOWN, RST_SLEEP_SILENCE,
                                     RST_START_HOLD, RST_END_HOLD, RST_MIN_SPEECH,
                                     RST_MIN_REACT_INTV);
                default: program_durations($urandom_range(0, 300), $urandom_range(0, 600),
                                           $urandom_range(200, 5000), $urandom_range(0, 300),
                                           $urandom_range(0, 500), $urandom_range(0, 800),
                                           $urandom_range(0, 4000));
            endcase
            // with maximal waits only a full-range time step ends startup
            if (phase == 3) begin
                offer_item(OP_RESTART, t_ms, F_OK, 16'd0, 16'd0, 16'd0);
                offer_item(OP_UPDATE, t_ms - 1, F_OK, 16'd0, 16'd0, 16'd0);
            end
            tx_calm = (phase == 5);
            if (phase == 2) begin
                random_burst(100);
                hold_req <= 1'b1;
                random_burst(130);
            end else begin
                random_burst(230);
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
